/* sv/csc_pkg.sv */
// Shared types and constants for the conical shadow classifier.
// Used by csc_datapath, conical_shadow_classifier_top and csc_checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package csc_pkg;

    // Configuration register indexes and reset values.
    localparam int unsigned CFG_IDX_W      = 1;
    localparam int unsigned CFG_DATA_W     = 30;
    localparam logic [CFG_IDX_W-1:0] REG_EARTH_RADIUS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SUN_RADIUS   = 1'd1;
    localparam logic [23:0] EARTH_RADIUS_RESET = 24'd6371000;
    localparam logic [29:0] SUN_RADIUS_RESET   = 30'd696999999;

    // Result classes.
    localparam logic [1:0] CLS_SUNLIT   = 2'd0;
    localparam logic [1:0] CLS_PENUMBRA = 2'd1;
    localparam logic [1:0] CLS_UMBRA    = 2'd2;

    // Root and quotient pipeline shapes.
    localparam int unsigned SQRT_STEPS = 56;   // root bits of a 112-bit radicand
    localparam int unsigned SQ_IN_W    = 112;
    localparam int unsigned SQ_ROOT_W  = 56;
    localparam int unsigned SQ_REM_W   = 59;
    localparam int unsigned DIV_STEPS  = 63;   // quotient bits below the overflow check
    localparam int unsigned DV_NUM_W   = 105;
    localparam int unsigned DV_HI_W    = 42;
    localparam int unsigned DV_REM_W   = 57;

    // Saturation limits.
    localparam logic [62:0] P_CAP   = 63'd1 << 49;
    localparam logic [62:0] TAN_CAP = 63'd1 << 62;
    localparam logic [72:0] R_CAP   = 73'd1 << 50;

    // Radius terms derived from the configuration registers.
    typedef struct packed {
        logic [23:0] re;
        logic [30:0] sum_r;
        logic [29:0] dif_r;
        logic        dif_neg;
        logic [61:0] sum_sq;
        logic [59:0] dif_sq;
    } t_cfg;

    // One classified item leaving the pipeline.
    typedef struct packed {
        logic       valid;
        logic [1:0] cls;
        logic       inv;
    } t_res;

endpackage

`default_nettype wire

/* sv/csc_datapath.sv */
// Pipelined datapath of the conical shadow classifier: dot products, three square
// roots, three divisions, cone radii and the final edge tests. Depends on csc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csc_datapath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_in_valid,
    input  wire logic [31:0]        i_sat_x,
    input  wire logic [31:0]        i_sat_y,
    input  wire logic [31:0]        i_sat_z,
    input  wire logic [39:0]        i_sun_x,
    input  wire logic [39:0]        i_sun_y,
    input  wire logic [39:0]        i_sun_z,
    input  wire csc_pkg::t_cfg      i_cfg,
    output csc_pkg::t_res           o_res
);

    localparam int unsigned NS = csc_pkg::SQRT_STEPS;
    localparam int unsigned ND = csc_pkg::DIV_STEPS;

    logic [31:0] w_sat [3];
    logic [39:0] w_sun [3];

    // Front stages: magnitudes, partial products, products, sums.
    logic        r_a0_vld, r_a1_vld, r_a2_vld, r_a3_vld;
    logic [31:0] r_a0_sm [3];
    logic [39:0] r_a0_vm [3];
    logic        r_a0_nk [3];
    logic [39:0] r_a1_vhh [3];
    logic [39:0] r_a1_vhl [3];
    logic [39:0] r_a1_vll [3];
    logic [63:0] r_a1_ss [3];
    logic [51:0] r_a1_svh [3];
    logic [51:0] r_a1_svl [3];
    logic        r_a1_nk [3];
    logic [79:0] r_a2_v2 [3];
    logic [71:0] r_a2_sv [3];
    logic [63:0] r_a2_ss [3];
    logic        r_a2_nk [3];
    logic [79:0] r_a3_d2;
    logic [63:0] r_a3_s2;
    logic [73:0] r_a3_pos, r_a3_neg;

    // Square root lanes: 0 sun distance, 1 umbra tangent root, 2 penumbra tangent root.
    logic [csc_pkg::SQ_IN_W-1:0]   r_sq_rad  [3][NS+1];
    logic [csc_pkg::SQ_REM_W-1:0]  r_sq_rem  [3][NS+1];
    logic [csc_pkg::SQ_ROOT_W-1:0] r_sq_root [3][NS+1];
    logic [csc_pkg::SQ_IN_W-1:0]   n_sq_rad  [3][NS+1];
    logic [csc_pkg::SQ_REM_W-1:0]  n_sq_rem  [3][NS+1];
    logic [csc_pkg::SQ_ROOT_W-1:0] n_sq_root [3][NS+1];
    logic        r_sq_vld [NS+1];
    logic        r_sq_inv [NS+1];
    logic        r_sq_sun [NS+1];
    logic [72:0] r_sq_q   [NS+1];
    logic [63:0] r_sq_s2  [NS+1];
    logic        n_a_inv, n_a_sun;
    logic [72:0] n_a_q;

    // Division lanes: 0 projection, 1 umbra tangent, 2 penumbra tangent.
    logic [ND-1:0]                 r_dv_lo   [3][ND+1];
    logic [csc_pkg::DV_REM_W-1:0]  r_dv_rem  [3][ND+1];
    logic [csc_pkg::SQ_ROOT_W-1:0] r_dv_den  [3][ND+1];
    logic [ND-1:0]                 r_dv_quot [3][ND+1];
    logic                          r_dv_ovf  [3][ND+1];
    logic [ND-1:0]                 n_dv_lo   [3][ND+1];
    logic [csc_pkg::DV_REM_W-1:0]  n_dv_rem  [3][ND+1];
    logic [ND-1:0]                 n_dv_quot [3][ND+1];
    logic                          n_dv_ovf  [3];
    logic [csc_pkg::DV_NUM_W-1:0]  w_dv_num  [3];
    logic        r_dv_vld [ND+1];
    logic        r_dv_inv [ND+1];
    logic        r_dv_sun [ND+1];
    logic [63:0] r_dv_s2  [ND+1];

    // Back stages.
    logic         r_d0_vld, r_d1_vld, r_d2_vld, r_d3_vld, r_d4_vld, r_d5_vld, r_d6_vld;
    logic         r_d0_inv, r_d1_inv, r_d2_inv, r_d3_inv, r_d4_inv, r_d5_inv, r_d6_inv;
    logic         r_d0_sun, r_d1_sun, r_d2_sun, r_d3_sun, r_d4_sun, r_d5_sun, r_d6_sun;
    logic [49:0]  r_d0_p;
    logic [62:0]  r_d0_tu, r_d0_tp;
    logic [63:0]  r_d0_s2, r_d1_s2, r_d2_s2;
    logic [62:0]  n_d0_val [3];
    logic [48:0]  r_d1_uhh, r_d1_phh;
    logic [49:0]  r_d1_uhl, r_d1_phl;
    logic [62:0]  r_d1_ulh, r_d1_plh;
    logic [63:0]  r_d1_ull, r_d1_pll;
    logic [35:0]  r_d1_pp_hh;
    logic [49:0]  r_d1_pp_hl;
    logic [63:0]  r_d1_pp_ll;
    logic [112:0] r_d2_fu, r_d2_fp;
    logic [98:0]  r_d2_pp;
    logic [50:0]  r_d3_pu, r_d3_pp;
    logic [95:0]  r_d3_dd2, r_d4_dd2, r_d5_dd2, r_d6_dd2;
    logic [95:0]  w_s2w;
    logic [50:0]  r_d4_ru, r_d4_rp;
    logic         r_d4_uok, r_d5_uok, r_d6_uok;
    logic [50:0]  w_re_fx;
    logic [37:0]  r_d5_uhh, r_d5_phh;
    logic [50:0]  r_d5_uhl, r_d5_phl;
    logic [63:0]  r_d5_ull, r_d5_pll;
    logic [101:0] r_d6_r2u, r_d6_r2p;
    csc_pkg::t_res n_res;
    csc_pkg::t_res r_res;

    assign w_sat[0] = i_sat_x;
    assign w_sat[1] = i_sat_y;
    assign w_sat[2] = i_sat_z;
    assign w_sun[0] = i_sun_x;
    assign w_sun[1] = i_sun_y;
    assign w_sun[2] = i_sun_z;

    // Valid bits travel with the items and are the only reset state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a0_vld <= 1'b0;
            r_a1_vld <= 1'b0;
            r_a2_vld <= 1'b0;
            r_a3_vld <= 1'b0;
            for (int j = 0; j <= NS; j++) r_sq_vld[j] <= 1'b0;
            for (int j = 0; j <= ND; j++) r_dv_vld[j] <= 1'b0;
            r_d0_vld <= 1'b0;
            r_d1_vld <= 1'b0;
            r_d2_vld <= 1'b0;
            r_d3_vld <= 1'b0;
            r_d4_vld <= 1'b0;
            r_d5_vld <= 1'b0;
            r_d6_vld <= 1'b0;
            r_res.valid <= 1'b0;
        end else if (i_en) begin
            r_a0_vld <= i_in_valid;
            r_a1_vld <= r_a0_vld;
            r_a2_vld <= r_a1_vld;
            r_a3_vld <= r_a2_vld;
            r_sq_vld[0] <= r_a3_vld;
            for (int j = 1; j <= NS; j++) r_sq_vld[j] <= r_sq_vld[j-1];
            r_dv_vld[0] <= r_sq_vld[NS];
            for (int j = 1; j <= ND; j++) r_dv_vld[j] <= r_dv_vld[j-1];
            r_d0_vld <= r_dv_vld[ND];
            r_d1_vld <= r_d0_vld;
            r_d2_vld <= r_d1_vld;
            r_d3_vld <= r_d2_vld;
            r_d4_vld <= r_d3_vld;
            r_d5_vld <= r_d4_vld;
            r_d6_vld <= r_d5_vld;
            r_res.valid <= n_res.valid;
            r_res.cls   <= n_res.cls;
            r_res.inv   <= n_res.inv;
        end
    end

    // Front stages: magnitudes and sign products, then split multiplies, then sums.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_a0_sm[k] <= w_sat[k][31] ? 32'(-w_sat[k]) : w_sat[k];
                r_a0_vm[k] <= w_sun[k][39] ? 40'(-w_sun[k]) : w_sun[k];
                r_a0_nk[k] <= w_sat[k][31] ^ w_sun[k][39];

                r_a1_vhh[k] <= 40'(r_a0_vm[k][39:20]) * 40'(r_a0_vm[k][39:20]);
                r_a1_vhl[k] <= 40'(r_a0_vm[k][39:20]) * 40'(r_a0_vm[k][19:0]);
                r_a1_vll[k] <= 40'(r_a0_vm[k][19:0]) * 40'(r_a0_vm[k][19:0]);
                r_a1_ss[k]  <= 64'(r_a0_sm[k]) * 64'(r_a0_sm[k]);
                r_a1_svh[k] <= 52'(r_a0_sm[k]) * 52'(r_a0_vm[k][39:20]);
                r_a1_svl[k] <= 52'(r_a0_sm[k]) * 52'(r_a0_vm[k][19:0]);
                r_a1_nk[k]  <= r_a0_nk[k];

                r_a2_v2[k] <= (80'(r_a1_vhh[k]) << 40) + (80'(r_a1_vhl[k]) << 21)
                              + 80'(r_a1_vll[k]);
                r_a2_sv[k] <= (72'(r_a1_svh[k]) << 20) + 72'(r_a1_svl[k]);
                r_a2_ss[k] <= r_a1_ss[k];
                r_a2_nk[k] <= r_a1_nk[k];
            end
            r_a3_d2  <= r_a2_v2[0] + r_a2_v2[1] + r_a2_v2[2];
            r_a3_s2  <= r_a2_ss[0] + r_a2_ss[1] + r_a2_ss[2];
            r_a3_pos <= (r_a2_nk[0] ? 74'd0 : 74'(r_a2_sv[0]))
                      + (r_a2_nk[1] ? 74'd0 : 74'(r_a2_sv[1]))
                      + (r_a2_nk[2] ? 74'd0 : 74'(r_a2_sv[2]));
            r_a3_neg <= (r_a2_nk[0] ? 74'(r_a2_sv[0]) : 74'd0)
                      + (r_a2_nk[1] ? 74'(r_a2_sv[1]) : 74'd0)
                      + (r_a2_nk[2] ? 74'(r_a2_sv[2]) : 74'd0);
        end
    end

    // Entry of the root lanes, plus one digit-by-digit root step per stage.
    always_comb begin
        logic [csc_pkg::SQ_REM_W-1:0] cand;
        logic [csc_pkg::SQ_REM_W-1:0] trial;
        n_a_inv = (80'(i_cfg.sum_sq) >= r_a3_d2);
        n_a_sun = (r_a3_pos > r_a3_neg);
        n_a_q   = 73'(r_a3_neg - r_a3_pos);
        n_sq_rad[0][0] = {r_a3_d2, 32'b0};
        n_sq_rad[1][0] = {80'(r_a3_d2 - 80'(i_cfg.dif_sq)), 32'b0};
        n_sq_rad[2][0] = {80'(r_a3_d2 - 80'(i_cfg.sum_sq)), 32'b0};
        for (int l = 0; l < 3; l++) begin
            n_sq_rem[l][0]  = '0;
            n_sq_root[l][0] = '0;
            for (int j = 0; j < NS; j++) begin
                cand  = {r_sq_rem[l][j][csc_pkg::SQ_REM_W-3:0],
                         r_sq_rad[l][j][csc_pkg::SQ_IN_W-1 -: 2]};
                trial = {1'b0, r_sq_root[l][j], 2'b01};
                if (cand >= trial) begin
                    n_sq_rem[l][j+1]  = cand - trial;
                    n_sq_root[l][j+1] = {r_sq_root[l][j][csc_pkg::SQ_ROOT_W-2:0], 1'b1};
                end else begin
                    n_sq_rem[l][j+1]  = cand;
                    n_sq_root[l][j+1] = {r_sq_root[l][j][csc_pkg::SQ_ROOT_W-2:0], 1'b0};
                end
                n_sq_rad[l][j+1] = {r_sq_rad[l][j][csc_pkg::SQ_IN_W-3:0], 2'b00};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j <= NS; j++) begin
                for (int l = 0; l < 3; l++) begin
                    r_sq_rad[l][j]  <= n_sq_rad[l][j];
                    r_sq_rem[l][j]  <= n_sq_rem[l][j];
                    r_sq_root[l][j] <= n_sq_root[l][j];
                end
            end
            r_sq_inv[0] <= n_a_inv;
            r_sq_sun[0] <= n_a_sun;
            r_sq_q[0]   <= n_a_q;
            r_sq_s2[0]  <= r_a3_s2;
            for (int j = 1; j <= NS; j++) begin
                r_sq_inv[j] <= r_sq_inv[j-1];
                r_sq_sun[j] <= r_sq_sun[j-1];
                r_sq_q[j]   <= r_sq_q[j-1];
                r_sq_s2[j]  <= r_sq_s2[j-1];
            end
        end
    end

    // Division entry: overflow check on the top numerator bits, then one
    // restoring quotient bit per stage.
    assign w_dv_num[0] = {r_sq_q[NS], 32'b0};
    assign w_dv_num[1] = csc_pkg::DV_NUM_W'(i_cfg.dif_r) << 56;
    assign w_dv_num[2] = csc_pkg::DV_NUM_W'(i_cfg.sum_r) << 56;

    always_comb begin
        logic [csc_pkg::DV_REM_W-1:0] cand;
        for (int l = 0; l < 3; l++) begin
            n_dv_ovf[l] = ({14'b0, w_dv_num[l][csc_pkg::DV_NUM_W-1 -: csc_pkg::DV_HI_W]}
                           >= r_sq_root[l][NS]);
            n_dv_rem[l][0]  = csc_pkg::DV_REM_W'(
                                  w_dv_num[l][csc_pkg::DV_NUM_W-1 -: csc_pkg::DV_HI_W]);
            n_dv_lo[l][0]   = w_dv_num[l][ND-1:0];
            n_dv_quot[l][0] = '0;
            for (int j = 0; j < ND; j++) begin
                cand = {r_dv_rem[l][j][csc_pkg::DV_REM_W-2:0], r_dv_lo[l][j][ND-1]};
                if (cand >= {1'b0, r_dv_den[l][j]}) begin
                    n_dv_rem[l][j+1]  = cand - {1'b0, r_dv_den[l][j]};
                    n_dv_quot[l][j+1] = {r_dv_quot[l][j][ND-2:0], 1'b1};
                end else begin
                    n_dv_rem[l][j+1]  = cand;
                    n_dv_quot[l][j+1] = {r_dv_quot[l][j][ND-2:0], 1'b0};
                end
                n_dv_lo[l][j+1] = {r_dv_lo[l][j][ND-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 3; l++) begin
                r_dv_den[l][0] <= r_sq_root[l][NS];
                r_dv_ovf[l][0] <= n_dv_ovf[l];
                for (int j = 0; j <= ND; j++) begin
                    r_dv_rem[l][j]  <= n_dv_rem[l][j];
                    r_dv_lo[l][j]   <= n_dv_lo[l][j];
                    r_dv_quot[l][j] <= n_dv_quot[l][j];
                end
                for (int j = 1; j <= ND; j++) begin
                    r_dv_den[l][j] <= r_dv_den[l][j-1];
                    r_dv_ovf[l][j] <= r_dv_ovf[l][j-1];
                end
            end
            r_dv_inv[0] <= r_sq_inv[NS];
            r_dv_sun[0] <= r_sq_sun[NS];
            r_dv_s2[0]  <= r_sq_s2[NS];
            for (int j = 1; j <= ND; j++) begin
                r_dv_inv[j] <= r_dv_inv[j-1];
                r_dv_sun[j] <= r_dv_sun[j-1];
                r_dv_s2[j]  <= r_dv_s2[j-1];
            end
        end
    end

    // Saturate the quotients: projection at its cap, tangents at theirs.
    always_comb begin
        logic [62:0] cap;
        for (int l = 0; l < 3; l++) begin
            cap = (l == 0) ? csc_pkg::P_CAP : csc_pkg::TAN_CAP;
            if (r_dv_ovf[l][ND] || r_dv_quot[l][ND] > cap) begin
                n_d0_val[l] = cap;
            end else begin
                n_d0_val[l] = r_dv_quot[l][ND];
            end
        end
    end

    assign w_s2w   = {r_d2_s2, 32'b0};
    assign w_re_fx = 51'(i_cfg.re) << 16;

    // Back stages: split products, shifts with saturation, radii, squares, tests.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d0_p   <= n_d0_val[0][49:0];
            r_d0_tu  <= n_d0_val[1];
            r_d0_tp  <= n_d0_val[2];
            r_d0_s2  <= r_dv_s2[ND];
            r_d0_inv <= r_dv_inv[ND];
            r_d0_sun <= r_dv_sun[ND];

            r_d1_uhh   <= 49'(r_d0_p[49:32]) * 49'(r_d0_tu[62:32]);
            r_d1_uhl   <= 50'(r_d0_p[49:32]) * 50'(r_d0_tu[31:0]);
            r_d1_ulh   <= 63'(r_d0_p[31:0]) * 63'(r_d0_tu[62:32]);
            r_d1_ull   <= 64'(r_d0_p[31:0]) * 64'(r_d0_tu[31:0]);
            r_d1_phh   <= 49'(r_d0_p[49:32]) * 49'(r_d0_tp[62:32]);
            r_d1_phl   <= 50'(r_d0_p[49:32]) * 50'(r_d0_tp[31:0]);
            r_d1_plh   <= 63'(r_d0_p[31:0]) * 63'(r_d0_tp[62:32]);
            r_d1_pll   <= 64'(r_d0_p[31:0]) * 64'(r_d0_tp[31:0]);
            r_d1_pp_hh <= 36'(r_d0_p[49:32]) * 36'(r_d0_p[49:32]);
            r_d1_pp_hl <= 50'(r_d0_p[49:32]) * 50'(r_d0_p[31:0]);
            r_d1_pp_ll <= 64'(r_d0_p[31:0]) * 64'(r_d0_p[31:0]);
            r_d1_s2    <= r_d0_s2;
            r_d1_inv   <= r_d0_inv;
            r_d1_sun   <= r_d0_sun;

            r_d2_fu  <= (113'(r_d1_uhh) << 64) + (113'(r_d1_uhl) << 32)
                      + (113'(r_d1_ulh) << 32) + 113'(r_d1_ull);
            r_d2_fp  <= (113'(r_d1_phh) << 64) + (113'(r_d1_phl) << 32)
                      + (113'(r_d1_plh) << 32) + 113'(r_d1_pll);
            r_d2_pp  <= (99'(r_d1_pp_hh) << 64) + (99'(r_d1_pp_hl) << 33)
                      + 99'(r_d1_pp_ll);
            r_d2_s2  <= r_d1_s2;
            r_d2_inv <= r_d1_inv;
            r_d2_sun <= r_d1_sun;

            r_d3_pu  <= (r_d2_fu[112:40] > csc_pkg::R_CAP) ? 51'(csc_pkg::R_CAP)
                                                           : r_d2_fu[90:40];
            r_d3_pp  <= (r_d2_fp[112:40] > csc_pkg::R_CAP) ? 51'(csc_pkg::R_CAP)
                                                           : r_d2_fp[90:40];
            r_d3_dd2 <= ({3'b0, w_s2w} > r_d2_pp) ? 96'(w_s2w - r_d2_pp[95:0]) : 96'd0;
            r_d3_inv <= r_d2_inv;
            r_d3_sun <= r_d2_sun;

            r_d4_uok <= i_cfg.dif_neg || (r_d3_pu <= w_re_fx);
            r_d4_ru  <= i_cfg.dif_neg ? 51'(w_re_fx + r_d3_pu) : 51'(w_re_fx - r_d3_pu);
            r_d4_rp  <= 51'(w_re_fx + r_d3_pp);
            r_d4_dd2 <= r_d3_dd2;
            r_d4_inv <= r_d3_inv;
            r_d4_sun <= r_d3_sun;

            r_d5_uhh <= 38'(r_d4_ru[50:32]) * 38'(r_d4_ru[50:32]);
            r_d5_uhl <= 51'(r_d4_ru[50:32]) * 51'(r_d4_ru[31:0]);
            r_d5_ull <= 64'(r_d4_ru[31:0]) * 64'(r_d4_ru[31:0]);
            r_d5_phh <= 38'(r_d4_rp[50:32]) * 38'(r_d4_rp[50:32]);
            r_d5_phl <= 51'(r_d4_rp[50:32]) * 51'(r_d4_rp[31:0]);
            r_d5_pll <= 64'(r_d4_rp[31:0]) * 64'(r_d4_rp[31:0]);
            r_d5_uok <= r_d4_uok;
            r_d5_dd2 <= r_d4_dd2;
            r_d5_inv <= r_d4_inv;
            r_d5_sun <= r_d4_sun;

            r_d6_r2u <= (102'(r_d5_uhh) << 64) + (102'(r_d5_uhl) << 33) + 102'(r_d5_ull);
            r_d6_r2p <= (102'(r_d5_phh) << 64) + (102'(r_d5_phl) << 33) + 102'(r_d5_pll);
            r_d6_uok <= r_d5_uok;
            r_d6_dd2 <= r_d5_dd2;
            r_d6_inv <= r_d5_inv;
            r_d6_sun <= r_d5_sun;
        end
    end

    // Final classification: a near sun and the sunward side win over the cones.
    always_comb begin
        n_res.valid = r_d6_vld;
        n_res.inv   = r_d6_inv;
        if (r_d6_inv || r_d6_sun) begin
            n_res.cls = csc_pkg::CLS_SUNLIT;
        end else if (r_d6_uok && ({6'b0, r_d6_dd2} <= r_d6_r2u)) begin
            n_res.cls = csc_pkg::CLS_UMBRA;
        end else if ({6'b0, r_d6_dd2} <= r_d6_r2p) begin
            n_res.cls = csc_pkg::CLS_PENUMBRA;
        end else begin
            n_res.cls = csc_pkg::CLS_SUNLIT;
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

/* sv/conical_shadow_classifier_top.sv */
// Conical Earth shadow classifier: one satellite and sun position pair in, one class
// out per cycle while the pipeline is not stalled. A square-root pipeline forms the sun
// distance and tangent denominators, and a divider forms the projection and the two
// cone tangents. A two-entry output buffer lets the pipeline keep taking items while a
// result waits; input ready drops only when that buffer is full and a result is at the
// pipeline exit. Radius registers are to be written through a plain write port only
// while idle; the user must keep to this, as the block itself does not enforce it.
// Depends on csc_pkg and csc_datapath.
`timescale 1ns / 1ps
`default_nettype none

module conical_shadow_classifier_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [csc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [csc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [31:0]                    i_sat_x,
    input  wire logic [31:0]                    i_sat_y,
    input  wire logic [31:0]                    i_sat_z,
    input  wire logic [39:0]                    i_sun_x,
    input  wire logic [39:0]                    i_sun_y,
    input  wire logic [39:0]                    i_sun_z,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [1:0]                          o_shadow_class,
    output logic                                o_invalid
);

    logic [23:0]   r_re;
    logic [29:0]   r_rs;
    csc_pkg::t_cfg r_cfg;
    csc_pkg::t_res w_res;
    logic          w_en, w_push, w_pop;
    logic [1:0]    r_count;
    logic          r_wr, r_rd;
    logic [1:0]    r_fifo_cls [2];
    logic          r_fifo_inv [2];

    // Radius registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_re <= csc_pkg::EARTH_RADIUS_RESET;
            r_rs <= csc_pkg::SUN_RADIUS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                csc_pkg::REG_EARTH_RADIUS: r_re <= i_cfg_data[23:0];
                csc_pkg::REG_SUN_RADIUS:   r_rs <= i_cfg_data[29:0];
                default: ;
            endcase
        end
    end

    // Derived radius terms: sums and differences registered from the radius registers, squares from those.
    always_ff @(posedge i_clk) begin
        r_cfg.re      <= r_re;
        r_cfg.sum_r   <= 31'(r_re) + 31'(r_rs);
        r_cfg.dif_neg <= (r_rs < 30'(r_re));
        r_cfg.dif_r   <= (r_rs < 30'(r_re)) ? 30'(30'(r_re) - r_rs) : 30'(r_rs - 30'(r_re));
        r_cfg.sum_sq  <= 62'(r_cfg.sum_r) * 62'(r_cfg.sum_r);
        r_cfg.dif_sq  <= 60'(r_cfg.dif_r) * 60'(r_cfg.dif_r);
    end

    // The whole pipeline moves unless a result at its exit has no buffer slot.
    assign w_en       = !w_res.valid || (r_count != 2'd2);
    assign o_in_ready = w_en;
    assign w_push     = w_res.valid && w_en;
    assign w_pop      = (r_count != 2'd0) && i_out_ready;

    csc_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_in_valid (i_in_valid),
        .i_sat_x    (i_sat_x),
        .i_sat_y    (i_sat_y),
        .i_sat_z    (i_sat_z),
        .i_sun_x    (i_sun_x),
        .i_sun_y    (i_sun_y),
        .i_sun_z    (i_sun_z),
        .i_cfg      (r_cfg),
        .o_res      (w_res)
    );

    // Two-entry output buffer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (w_pop)  r_rd <= ~r_rd;
            r_count <= 2'(r_count + {1'b0, w_push} - {1'b0, w_pop});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo_cls[r_wr] <= w_res.cls;
            r_fifo_inv[r_wr] <= w_res.inv;
        end
    end

    assign o_out_valid    = (r_count != 2'd0);
    assign o_shadow_class = r_fifo_cls[r_rd];
    assign o_invalid      = r_fifo_inv[r_rd];

endmodule

`default_nettype wire

/* sv/csc_checker.sv */
// Port-level checks for the conical shadow classifier, bound to its top level.
// Depends on csc_pkg and conical_shadow_classifier_top.
`timescale 1ns / 1ps
`default_nettype none

module csc_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           o_in_ready,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_ready,
    input wire logic [1:0]                     o_shadow_class,
    input wire logic                           o_invalid
);

    // A shown result holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_shadow_class)
                                        && $stable(o_invalid))
        else $error("result changed while stalled");

    // An invalid geometry is always reported as sunlit.
    a_inv_sunlit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_invalid |-> o_shadow_class == csc_pkg::CLS_SUNLIT)
        else $error("invalid item not sunlit");

    // Only the three defined classes appear.
    a_cls_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_shadow_class == csc_pkg::CLS_SUNLIT
                        || o_shadow_class == csc_pkg::CLS_PENUMBRA
                        || o_shadow_class == csc_pkg::CLS_UMBRA)
        else $error("undefined class");

    // Input back-pressure only appears while results are waiting.
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result waiting");

endmodule

bind conical_shadow_classifier_top csc_checker u_csc_checker (.*);

`default_nettype wire

/* test/tb_conical_shadow_classifier_top.sv */
// Self-checking testbench for conical_shadow_classifier_top: directed table, then random
// position pairs under several radius settings, each result checked against a local predictor.
// Depends on csc_pkg and the classifier RTL.
`timescale 1ns / 1ps

module tb_conical_shadow_classifier_top;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int ITEMS_PER_SET  = 150;

    typedef bit [255:0] t_wide;

    typedef struct {
        logic [1:0] cls;
        logic       inv;
    } t_shadow;

    typedef struct {
        longint sat [3];
        longint sun [3];
    } t_pair;

    // Directed row: typed expectation applies only when has_typed is set.
    typedef struct {
        longint     sat [3];
        longint     sun [3];
        bit         has_typed;
        logic [1:0] cls;
        logic       inv;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [csc_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [csc_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [31:0] i_sat_x, i_sat_y, i_sat_z;
    logic [39:0] i_sun_x, i_sun_y, i_sun_z;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_shadow_class;
    logic        o_invalid;

    conical_shadow_classifier_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_sat_x(i_sat_x), .i_sat_y(i_sat_y), .i_sat_z(i_sat_z),
        .i_sun_x(i_sun_x), .i_sun_y(i_sun_y), .i_sun_z(i_sun_z),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_shadow_class(o_shadow_class), .o_invalid(o_invalid)
    );

    // Predictor copy of the radius registers and the queue of pending classes.
    logic [23:0] earth_r;
    logic [29:0] sun_r;
    t_shadow     pending_q [$];
    bit          failed;
    int          idle_cycles;
    int          burst_left;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_wide isqrt(t_wide n);
        logic [63:0] root;
        logic [63:0] cand;
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (t_wide'(cand) * t_wide'(cand) <= n) root = cand;
        end
        return t_wide'(root);
    endfunction

    function automatic t_wide sat_at(t_wide v, t_wide cap);
        return (v > cap) ? cap : v;
    endfunction

    // Tangent of a cone half angle in Q40: num / sqrt(den2), saturated.
    function automatic t_wide cone_tan(t_wide num, t_wide den2);
        t_wide root;
        root = isqrt(den2 << 32);
        if (root == 0) return t_wide'(csc_pkg::TAN_CAP);
        return sat_at((num << 56) / root, t_wide'(csc_pkg::TAN_CAP));
    endfunction

    // Conical shadow classification at fixed point.
    function automatic t_shadow classify(t_pair it);
        t_shadow res;
        t_wide   d2, s2, pos, negs, sm, vm, q, d_fx, p_fx, tu, tp, prod_u, prod_p;
        t_wide   dd2, pp, re_w, sum_r, dif_r, re_fx, r_u, r_p;
        bit      dif_neg;
        longint  sv, vv;
        d2 = 0; s2 = 0; pos = 0; negs = 0;
        re_w    = t_wide'(earth_r);
        sum_r   = re_w + t_wide'(sun_r);
        dif_neg = sun_r < earth_r;
        dif_r   = dif_neg ? re_w - t_wide'(sun_r) : t_wide'(sun_r) - re_w;
        for (int k = 0; k < 3; k++) begin
            sv = it.sat[k];
            vv = it.sun[k];
            sm = t_wide'(sv < 0 ? -sv : sv);
            vm = t_wide'(vv < 0 ? -vv : vv);
            d2 += vm * vm;
            s2 += sm * sm;
            if ((sv < 0) != (vv < 0)) negs += sm * vm;
            else pos += sm * vm;
        end
        res.cls = csc_pkg::CLS_SUNLIT;
        res.inv = 1'b0;
        // Sun inside the sum of radii: flagged, reported sunlit.
        if (d2 <= sum_r * sum_r) begin
            res.inv = 1'b1;
            return res;
        end
        // Satellite on the sunward side.
        if (pos > negs) return res;
        q      = negs - pos;
        d_fx   = isqrt(d2 << 32);
        p_fx   = sat_at((q << 32) / d_fx, t_wide'(csc_pkg::P_CAP));
        tu     = cone_tan(dif_r, d2 - dif_r * dif_r);
        tp     = cone_tan(sum_r, d2 - sum_r * sum_r);
        prod_u = sat_at((p_fx * tu) >> 40, t_wide'(csc_pkg::R_CAP));
        prod_p = sat_at((p_fx * tp) >> 40, t_wide'(csc_pkg::R_CAP));
        pp     = p_fx * p_fx;
        dd2    = s2 << 32;
        dd2    = (dd2 > pp) ? dd2 - pp : 0;
        re_fx  = re_w << 16;
        // Umbra cone, absent when its radius would be negative.
        if (dif_neg || prod_u <= re_fx) begin
            r_u = dif_neg ? re_fx + prod_u : re_fx - prod_u;
            if (dd2 <= r_u * r_u) begin
                res.cls = csc_pkg::CLS_UMBRA;
                return res;
            end
        end
        r_p = re_fx + prod_p;
        if (dd2 <= r_p * r_p) res.cls = csc_pkg::CLS_PENUMBRA;
        return res;
    endfunction

    // Random 40-bit two's complement value, sign-extended.
    function automatic longint rand40();
        return longint'($signed({8'($urandom_range(0, 255)), $urandom()}));
    endfunction

    // Random pair: mostly a satellite near the shadow axis, some raw noise.
    function automatic t_pair random_pair();
        t_pair it;
        int    pick, sh;
        pick = $urandom_range(0, 99);
        for (int k = 0; k < 3; k++) it.sun[k] = rand40();
        if (pick < 70) begin
            sh = $urandom_range(11, 17);
            for (int k = 0; k < 3; k++)
                it.sat[k] = -(it.sun[k] >>> sh) + $urandom_range(0, 32000000) - 16000000;
        end else if (pick < 85) begin
            for (int k = 0; k < 3; k++) it.sat[k] = longint'($signed($urandom()));
        end else begin
            for (int k = 0; k < 3; k++) begin
                it.sat[k] = longint'($urandom_range(0, 40000000)) - 20000000;
                if ($urandom_range(0, 3) == 0) it.sun[k] = it.sun[k] >>> $urandom_range(8, 30);
            end
        end
        return it;
    endfunction

    // Drive one item and hold it until accepted; valid stays high afterwards.
    task automatic send_pair(t_pair it);
        i_in_valid <= 1'b1;
        i_sat_x <= it.sat[0][31:0];
        i_sat_y <= it.sat[1][31:0];
        i_sat_z <= it.sat[2][31:0];
        i_sun_x <= it.sun[0][39:0];
        i_sun_y <= it.sun[1][39:0];
        i_sun_z <= it.sun[2][39:0];
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Sender burst pacing: a random gap after each burst, sometimes none.
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [csc_pkg::CFG_IDX_W-1:0] idx,
                             logic [csc_pkg::CFG_DATA_W-1:0] data);
        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == csc_pkg::REG_EARTH_RADIUS) earth_r = data[23:0];
        else sun_r = data[29:0];
    endtask

    // Accepted item: queue the predicted class.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            pending_q.push_back(classify('{sat: '{longint'($signed(i_sat_x)),
                longint'($signed(i_sat_y)), longint'($signed(i_sat_z))},
                sun: '{longint'($signed(i_sun_x)), longint'($signed(i_sun_y)),
                longint'($signed(i_sun_z))}}));
    end

    // Result check against the oldest expectation.
    always @(posedge i_clk) begin
        t_shadow want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result class=%0d invalid=%0d", $realtime,
                    o_shadow_class, o_invalid);
                failed = 1'b1;
            end else begin
                want = pending_q.pop_front();
                if (o_shadow_class !== want.cls) begin
                    $display("%0t: shadow_class expected %0d actual %0d", $realtime,
                        want.cls, o_shadow_class);
                    failed = 1'b1;
                end
                if (o_invalid !== want.inv) begin
                    $display("%0t: invalid expected %0d actual %0d", $realtime,
                        want.inv, o_invalid);
                    failed = 1'b1;
                end
            end
        end
    end

    // Receiver stalls: ready always, mostly ready, or often stalled, chosen by time epoch.
    always @(posedge i_clk) begin
        int epoch;
        epoch = int'($time / 64'd4096);
        case (epoch % 3)
            0: begin
                i_out_ready <= 1'b1;
            end
            1: begin
                i_out_ready <= ($urandom_range(0, 99) < 75);
            end
            default: begin
                i_out_ready <= ($urandom_range(0, 99) < 35);
            end
        endcase
    end

    // Watchdog on cycles with no accepted item at either side.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        t_row  rows [$];
        t_pair it;
        t_shadow got;
        longint big, low, sun_far;
        failed      = 1'b0;
        idle_cycles = 0;
        burst_left  = 0;
        earth_r     = csc_pkg::EARTH_RADIUS_RESET;
        sun_r       = csc_pkg::SUN_RADIUS_RESET;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = csc_pkg::REG_EARTH_RADIUS;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_out_ready = 1'b1;
        {i_sat_x, i_sat_y, i_sat_z} = '0;
        {i_sun_x, i_sun_y, i_sun_z} = '0;
        big     = 64'sd549755813887;
        low     = -64'sd549755813888;
        sun_far = 64'sd150000000000;

        // Directed rows, default radii.
        rows = '{
            // Zero sun vector: flagged.
            '{'{0, 0, 0}, '{0, 0, 0}, 1, csc_pkg::CLS_SUNLIT, 1'b1},
            // Sun inside the radius sum: flagged.
            '{'{-7000000, 0, 0}, '{1000, 0, 0}, 1, csc_pkg::CLS_SUNLIT, 1'b1},
            // Sunward satellite.
            '{'{7000000, 0, 0}, '{big, 0, 0}, 1, csc_pkg::CLS_SUNLIT, 1'b0},
            '{'{2147483647, 2147483647, 2147483647}, '{big, big, big}, 1,
              csc_pkg::CLS_SUNLIT, 1'b0},
            // Satellite at the center: perpendicular projection, umbra.
            '{'{0, 0, 0}, '{sun_far, 0, 0}, 1, csc_pkg::CLS_UMBRA, 1'b0},
            '{'{-7000000, 0, 0}, '{big, 0, 0}, 0, csc_pkg::CLS_SUNLIT, 1'b0},
            '{'{-2147483648, -2147483648, -2147483648}, '{low, low, low}, 0,
              csc_pkg::CLS_SUNLIT, 1'b0},
            '{'{-2147483648, 0, 0}, '{sun_far, 0, 0}, 0, csc_pkg::CLS_SUNLIT, 1'b0},
            '{'{-2147483648, 20000000, 0}, '{sun_far, 0, 0}, 0, csc_pkg::CLS_SUNLIT, 1'b0},
            // Edge of the body disk at zero projection.
            '{'{0, 6371000, 0}, '{sun_far, 0, 0}, 0, csc_pkg::CLS_SUNLIT, 1'b0},
            '{'{0, 6371001, 0}, '{sun_far, 0, 0}, 0, csc_pkg::CLS_SUNLIT, 1'b0},
            '{'{-1000000000, 0, 0}, '{big, 0, 0}, 0, csc_pkg::CLS_SUNLIT, 1'b0},
            '{'{-1000000000, 3000000, 0}, '{big, 0, 0}, 0, csc_pkg::CLS_SUNLIT, 1'b0},
            '{'{2147483647, -2147483648, 0}, '{low, big, 1}, 0, csc_pkg::CLS_SUNLIT, 1'b0},
            '{'{0, 0, -9000000}, '{0, 0, 703371000}, 0, csc_pkg::CLS_SUNLIT, 1'b0}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            it.sat = rows[r].sat;
            it.sun = rows[r].sun;
            if (rows[r].has_typed) begin
                got = classify(it);
                if (got.cls !== rows[r].cls || got.inv !== rows[r].inv) begin
                    $display("%0t: row %0d typed class %0d/%0d, predicted %0d/%0d",
                        $realtime, r, rows[r].cls, rows[r].inv, got.cls, got.inv);
                    failed = 1'b1;
                end
            end
            send_pair(it);
            pace();
        end

        // Random items across radius settings, extremes included.
        for (int set = 0; set < 7; set++) begin
            case (set)
                1: begin
                    write_reg(csc_pkg::REG_EARTH_RADIUS, 30'h00FFFFFF);
                    write_reg(csc_pkg::REG_SUN_RADIUS, 30'h3FFFFFFF);
                end
                2: begin
                    write_reg(csc_pkg::REG_EARTH_RADIUS, 30'd1);
                    write_reg(csc_pkg::REG_SUN_RADIUS, 30'd1);
                end
                3: begin
                    // Source smaller than the body.
                    write_reg(csc_pkg::REG_EARTH_RADIUS, 30'd6371000);
                    write_reg(csc_pkg::REG_SUN_RADIUS, 30'd1737000);
                end
                4: begin
                    // Zero radii, with bits above the earth register width.
                    write_reg(csc_pkg::REG_EARTH_RADIUS, 30'h3F000000);
                    write_reg(csc_pkg::REG_SUN_RADIUS, 30'd0);
                end
                5: begin
                    write_reg(csc_pkg::REG_EARTH_RADIUS, 30'($urandom()));
                    write_reg(csc_pkg::REG_SUN_RADIUS, 30'($urandom()));
                end
                6: begin
                    write_reg(csc_pkg::REG_EARTH_RADIUS, 30'(csc_pkg::EARTH_RADIUS_RESET));
                    write_reg(csc_pkg::REG_SUN_RADIUS, 30'(csc_pkg::SUN_RADIUS_RESET));
                end
                default: ;
            endcase
            for (int n = 0; n < ITEMS_PER_SET; n++) begin
                send_pair(random_pair());
                if (n == ITEMS_PER_SET / 2) drain();
                else pace();
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failed || pending_q.size() != 0) begin
            $display("tb: failure");
        end else begin
            $display("tb: success");
        end
        $finish;
    end

endmodule
